>>> rtl/assert_macros.svh
// assertion helpers used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// condition that must never be true outside reset
`define ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, prop)
`define ASSERT_NEVER(name, cond)
`endif

`endif

>>> rtl/pfq_pkg.sv
package pfq_pkg;

	// default configuration
	localparam int LEVELS_DEF       = 5;
	localparam int DEPTH_DEF        = 16;
	localparam int ID_BITS_DEF      = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// fixed port widths
	localparam int PRIO_W     = 4;
	localparam int PAY_PORT_W = 32;
	localparam int ID_PORT_W  = 16;
	localparam int STAT_W     = 32;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_PRIO = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// decision made for one item in the first stage
	typedef struct packed {
		logic                  deq;
		status_t               status;
		logic [PRIO_W-1:0]     prio;
		logic [PRIO_W-1:0]     steps;
	} op_info_t;

endpackage

>>> rtl/pfq_mem.sv
module pfq_mem #(
	parameter int ENTRIES = pfq_pkg::LEVELS_DEF * pfq_pkg::DEPTH_DEF,
	parameter int DATA_W  = pfq_pkg::ID_BITS_DEF + pfq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] addr,
	input  logic [DATA_W-1:0]          wdata,
	output logic [DATA_W-1:0]          rdata
);

	logic [DATA_W-1:0] mem [ENTRIES];
	logic [DATA_W-1:0] rdata_q;

	// single port entry store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pfq_ctrl.sv
module pfq_ctrl #(
	parameter int LEVELS      = pfq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = pfq_pkg::DEPTH_DEF,
	parameter int ID_BITS     = pfq_pkg::ID_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  logic                                  action,
	input  logic [2:0]                            prio_req,
	output pfq_pkg::op_info_t                     info,
	output logic [ID_BITS-1:0]                    id,
	output logic                                  mem_we,
	output logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0] mem_addr
);

	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int LV_W   = $clog2(LEVELS);
	localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
	localparam int PW     = pfq_pkg::PRIO_W;

	logic [CNT_W-1:0]   cnt_q  [LEVELS];
	logic [PTR_W-1:0]   head_q [LEVELS];
	logic [PTR_W-1:0]   tail_q [LEVELS];
	logic [ID_BITS-1:0] next_id_q;

	logic [PW-1:0]    prio_ext;
	logic [LEVELS-1:0] enq_hit;
	logic             bad, full, found;
	logic [LV_W-1:0]  enq_lv, deq_lv;
	logic [PTR_W-1:0] enq_ptr, deq_ptr;
	logic             do_enq, do_deq;

	// level lookup for enqueue and highest non-empty level for dequeue
	always_comb begin
		prio_ext = PW'(prio_req);
		bad      = (prio_ext == '0) || (prio_ext > PW'(LEVELS));
		full     = 1'b0;
		enq_lv   = '0;
		enq_ptr  = '0;
		found    = 1'b0;
		deq_lv   = '0;
		deq_ptr  = '0;
		for (int l = 0; l < LEVELS; l++) begin
			enq_hit[l] = (prio_ext == PW'(l + 1));
			if (enq_hit[l]) begin
				full    = (cnt_q[l] == CNT_W'(LEVEL_DEPTH));
				enq_lv  = LV_W'(l);
				enq_ptr = tail_q[l];
			end
			if (cnt_q[l] != '0) begin
				found   = 1'b1;
				deq_lv  = LV_W'(l);
				deq_ptr = head_q[l];
			end
		end
	end

	assign do_enq = !action && !bad && !full;
	assign do_deq = action && found;

	// decision handed to the next stage
	always_comb begin
		info.deq   = action;
		info.prio  = '0;
		info.steps = '0;
		if (action) begin
			info.status = found ? pfq_pkg::ST_OK : pfq_pkg::ST_EMPTY;
			info.steps  = found ? PW'(LEVELS) - PW'(deq_lv) : PW'(LEVELS);
			info.prio   = found ? PW'(deq_lv) + PW'(1) : '0;
		end else if (bad) begin
			info.status = pfq_pkg::ST_BAD_PRIO;
		end else if (full) begin
			info.status = pfq_pkg::ST_FULL;
		end else begin
			info.status = pfq_pkg::ST_OK;
		end
	end

	// slot address: tail on enqueue, head on dequeue
	always_comb begin
		if (action) begin
			mem_addr = ADDR_W'(deq_lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(deq_ptr);
		end else begin
			mem_addr = ADDR_W'(enq_lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(enq_ptr);
		end
	end

	assign id     = next_id_q;
	assign mem_we = step && do_enq;

	// per level pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l]  <= '0;
				head_q[l] <= '0;
				tail_q[l] <= '0;
			end
		end else if (step) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (do_enq && enq_lv == LV_W'(l)) begin
					cnt_q[l]  <= cnt_q[l] + CNT_W'(1);
					tail_q[l] <= (tail_q[l] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
						: tail_q[l] + PTR_W'(1);
				end
				if (do_deq && deq_lv == LV_W'(l)) begin
					cnt_q[l]  <= cnt_q[l] - CNT_W'(1);
					head_q[l] <= (head_q[l] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
						: head_q[l] + PTR_W'(1);
				end
			end
		end
	end

	// running id, skips zero on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= ID_BITS'(1);
		end else if (step && do_enq) begin
			next_id_q <= (next_id_q == '1) ? ID_BITS'(1) : next_id_q + ID_BITS'(1);
		end
	end

endmodule

>>> rtl/pfq_stats.sv
module pfq_stats #(
	parameter int LEVELS   = pfq_pkg::LEVELS_DEF,
	parameter int ID_BITS  = pfq_pkg::ID_BITS_DEF,
	parameter int STORE_W  = pfq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               v_s2,
	input  pfq_pkg::op_info_t                  info_s2,
	input  logic [ID_BITS-1:0]                 id_s2,
	input  logic [ID_BITS-1:0]                 rd_id,
	input  logic [STORE_W-1:0]                 rd_pay,
	output logic [1:0]                         status,
	output logic [pfq_pkg::ID_PORT_W-1:0]      doc_id,
	output logic [2:0]                         served_priority,
	output logic [pfq_pkg::PAY_PORT_W-1:0]     served_payload,
	output logic [2:0]                         steps,
	output logic [pfq_pkg::STAT_W-1:0]         served_total,
	output logic [pfq_pkg::STAT_W-1:0]         served_id_sum,
	output logic [2:0]                         min_served_priority,
	output logic [2:0]                         max_served_priority
);

	localparam int SW = pfq_pkg::STAT_W;
	localparam int PW = pfq_pkg::PRIO_W;

	logic [SW-1:0] total_q, sum_q;
	logic [PW-1:0] min_q, max_q;
	logic          ok, ok_deq;
	logic [SW:0]   sum_wide;

	logic [1:0]                     status_q;
	logic [pfq_pkg::ID_PORT_W-1:0]  doc_id_q;
	logic [2:0]                     sprio_q, steps_q;
	logic [pfq_pkg::PAY_PORT_W-1:0] spay_q;

	assign ok       = (info_s2.status == pfq_pkg::ST_OK);
	assign ok_deq   = v_s2 && info_s2.deq && ok;
	assign sum_wide = {1'b0, sum_q} + (SW + 1)'(rd_id);

	// served statistics, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			sum_q   <= '0;
			min_q   <= PW'(LEVELS);
			max_q   <= PW'(1);
		end else if (adv && ok_deq) begin
			total_q <= (total_q == '1) ? total_q : total_q + SW'(1);
			sum_q   <= sum_wide[SW] ? '1 : sum_wide[SW-1:0];
			if (info_s2.prio < min_q) begin
				min_q <= info_s2.prio;
			end
			if (info_s2.prio > max_q) begin
				max_q <= info_s2.prio;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			status_q <= info_s2.status;
			sprio_q  <= info_s2.prio[2:0];
			steps_q  <= info_s2.steps[2:0];
			if (!ok) begin
				doc_id_q <= '0;
			end else if (info_s2.deq) begin
				doc_id_q <= pfq_pkg::ID_PORT_W'(rd_id);
			end else begin
				doc_id_q <= pfq_pkg::ID_PORT_W'(id_s2);
			end
			spay_q <= ok_deq ? pfq_pkg::PAY_PORT_W'(rd_pay) : '0;
		end
	end

	assign status              = status_q;
	assign doc_id              = doc_id_q;
	assign served_priority     = sprio_q;
	assign served_payload      = spay_q;
	assign steps               = steps_q;
	assign served_total        = total_q;
	assign served_id_sum       = sum_q;
	assign min_served_priority = min_q[2:0];
	assign max_served_priority = max_q[2:0];

endmodule

>>> rtl/five_level_priority_fifo_queue_top.sv
// path: input register, then store read and decision register, then result register
// throughput: one item per cycle, bounded by the single port entry store access per item
// the whole pipeline holds while a finished result waits for out_ready
// reset: asynchronous active low; empties every level, next id 1, statistics cleared
// (min served priority LEVELS, max 1); the entry store itself is not cleared
`include "assert_macros.svh"

module five_level_priority_fifo_queue_top #(
	parameter int LEVELS       = pfq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH  = pfq_pkg::DEPTH_DEF,
	parameter int ID_BITS      = pfq_pkg::ID_BITS_DEF,
	parameter int PAYLOAD_BITS = pfq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [2:0]                     priority_req,
	input  logic [pfq_pkg::PAY_PORT_W-1:0] payload,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [pfq_pkg::ID_PORT_W-1:0]  doc_id,
	output logic [2:0]                     served_priority,
	output logic [pfq_pkg::PAY_PORT_W-1:0] served_payload,
	output logic [2:0]                     steps,
	output logic [pfq_pkg::STAT_W-1:0]     served_total,
	output logic [pfq_pkg::STAT_W-1:0]     served_id_sum,
	output logic [2:0]                     min_served_priority,
	output logic [2:0]                     max_served_priority
);

	localparam int STORE_W = (PAYLOAD_BITS < pfq_pkg::PAY_PORT_W) ? PAYLOAD_BITS
		: pfq_pkg::PAY_PORT_W;
	localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int DATA_W  = ID_BITS + STORE_W;

	logic                 adv, step;
	logic                 out_valid_q;
	logic                 v_s1, v_s2;
	logic                 action_s1;
	logic [2:0]           prio_s1;
	logic [STORE_W-1:0]   pay_s1;
	pfq_pkg::op_info_t    info, info_s2;
	logic [ID_BITS-1:0]   id, id_s2;
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_addr;
	logic [DATA_W-1:0]    rdata;
	logic                 err_fields;

	// pipeline moves whenever the result register is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign step     = adv && v_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			action_s1 <= action;
			prio_s1   <= priority_req;
			pay_s1    <= payload[STORE_W-1:0];
		end
	end

	pfq_ctrl #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.action   (action_s1),
		.prio_req (prio_s1),
		.info     (info),
		.id       (id),
		.mem_we   (mem_we),
		.mem_addr (mem_addr)
	);

	pfq_mem #(
		.ENTRIES (ENTRIES),
		.DATA_W  (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (adv),
		.addr  (mem_addr),
		.wdata ({id, pay_s1}),
		.rdata (rdata)
	);

	// decision register, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			info_s2 <= info;
			id_s2   <= id;
		end
	end

	pfq_stats #(
		.LEVELS  (LEVELS),
		.ID_BITS (ID_BITS),
		.STORE_W (STORE_W)
	) u_stats (
		.clk                 (clk),
		.arst_n              (arst_n),
		.adv                 (adv),
		.v_s2                (v_s2),
		.info_s2             (info_s2),
		.id_s2               (id_s2),
		.rd_id               (rdata[DATA_W-1:STORE_W]),
		.rd_pay              (rdata[STORE_W-1:0]),
		.status              (status),
		.doc_id              (doc_id),
		.served_priority     (served_priority),
		.served_payload      (served_payload),
		.steps               (steps),
		.served_total        (served_total),
		.served_id_sum       (served_id_sum),
		.min_served_priority (min_served_priority),
		.max_served_priority (max_served_priority)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	assign err_fields = (doc_id != '0) || (served_payload != '0);

	`ASSERT_CLK(a_total_monotonic, served_total >= $past(served_total))
	`ASSERT_CLK(a_min_le_max, (served_total != '0) |-> (min_served_priority <= max_served_priority))
	`ASSERT_NEVER(a_error_fields_zero, out_valid && (status != pfq_pkg::ST_OK) && err_fields)

endmodule
